>>> hdl/status_led_animation_controller_macros.svh
// Assertion macros shared by the status LED animation controller RTL.
// Needs a clk and an active-low rst_n in the scope that uses them.
`ifndef STATUS_LED_ANIMATION_CONTROLLER_MACROS_SVH
`define STATUS_LED_ANIMATION_CONTROLLER_MACROS_SVH
`ifndef ASSERT_OFF
`define SLAC_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define SLAC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);
`else
`define SLAC_ASSERT(label, expr, msg)
`define SLAC_ASSERT_NEXT(label, cond, expr, msg)
`endif
`endif

>>> hdl/slac_pkg.sv
// Types, constants, level tables and helper functions of the status LED animator.
// No dependencies.
`default_nettype none

package slac_pkg;

  localparam int unsigned TICK_MS = 50;

  localparam int PHASE_W = 32;
  localparam longint unsigned PHASE_SPAN = 64'd1 << PHASE_W;

  localparam int unsigned BOOT_STEP_MS      = 100;
  localparam int unsigned BOOT_WHITE_END_MS = 400;
  localparam int unsigned BOOT_END_MS       = 800;
  localparam int unsigned BLINK_HALF_MS     = 200;

  localparam int unsigned BREATHE_PERIOD = 4000;
  localparam int unsigned PULSE_PERIOD   = 1500;
  localparam int unsigned BLINK_PERIOD   = 2 * BLINK_HALF_MS;

  localparam int unsigned BREATHE_PEAK = 30;
  localparam int unsigned PULSE_PEAK   = 60;

  localparam logic [7:0] BOOT_LEVEL  = 8'd20;
  localparam logic [7:0] BLINK_LEVEL = 8'd80;

  // phase residues after a 2^32 wrap
  localparam int unsigned BREATHE_WRAP = int'(PHASE_SPAN % BREATHE_PERIOD);
  localparam int unsigned PULSE_WRAP   = int'(PHASE_SPAN % PULSE_PERIOD);
  localparam int unsigned BLINK_WRAP   = int'(PHASE_SPAN % BLINK_PERIOD);

  localparam int BR_W  = $clog2(BREATHE_PERIOD);
  localparam int PU_W  = $clog2(PULSE_PERIOD);
  localparam int BL_W  = $clog2(BLINK_PERIOD);
  localparam int MOD_W = $clog2(3 * BREATHE_PERIOD);

  // sine index = floor(m * 128 / period) as a reciprocal multiply
  localparam int IDX_W  = 7;
  localparam int IDX_SH = 21;
  localparam int unsigned BREATHE_IDX_MUL =
    int'(((64'd1 << (IDX_SH + IDX_W)) + 64'(BREATHE_PERIOD) - 64'd1) / 64'(BREATHE_PERIOD));
  localparam int unsigned PULSE_IDX_MUL =
    int'(((64'd1 << (IDX_SH + IDX_W)) + 64'(PULSE_PERIOD) - 64'd1) / 64'(PULSE_PERIOD));

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_FAULT = 1'b1;

  localparam logic [1:0] OVEN_RUNNING = 2'd1;
  localparam logic [1:0] OVEN_FAULT   = 2'd2;

  localparam logic [1:0] CODE_BOOT    = 2'd0;
  localparam logic [1:0] CODE_BREATHE = 2'd1;
  localparam logic [1:0] CODE_PULSE   = 2'd2;
  localparam logic [1:0] CODE_FAULT   = 2'd3;

  typedef enum logic [3:0] {
    MODE_BOOT    = 4'b0001,
    MODE_BREATHE = 4'b0010,
    MODE_PULSE   = 4'b0100,
    MODE_FAULT   = 4'b1000
  } mode_t;

  // quarter-wave sine, 65536 * sin(k * pi / 64)
  localparam int unsigned SINQ [0:32] = '{
    0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
    25079, 28020, 30893, 33692, 36410, 39040, 41576, 44011,
    46341, 48559, 50660, 52639, 54491, 56212, 57798, 59244,
    60547, 61705, 62714, 63572, 64277, 64827, 65220, 65457,
    65536
  };

  typedef logic [7:0] lvl_tab_t [0:(1 << IDX_W) - 1];

  function automatic lvl_tab_t build_lvl(int unsigned peak, bit third);
    lvl_tab_t    tab;
    int unsigned mag;
    int unsigned biased;
    int unsigned lvl;
    for (int i = 0; i < (1 << IDX_W); i++) begin
      mag    = ((i >> 5) & 1) != 0 ? SINQ[32 - (i & 31)] : SINQ[i & 31];
      biased = ((i >> 5) & 2) != 0 ? 65536 - mag : 65536 + mag;
      lvl    = (peak * biased) >> 17;
      if (third) begin
        lvl = lvl / 3;
      end
      tab[i] = 8'(lvl);
    end
    return tab;
  endfunction

  localparam lvl_tab_t BREATHE_LVL     = build_lvl(BREATHE_PEAK, 1'b0);
  localparam lvl_tab_t PULSE_RED_LVL   = build_lvl(PULSE_PEAK, 1'b0);
  localparam lvl_tab_t PULSE_GREEN_LVL = build_lvl(PULSE_PEAK, 1'b1);

  // advance a phase residue by one tick, folding in the 2^32 wrap
  function automatic logic [MOD_W-1:0] mod_step(logic [MOD_W-1:0] cur, logic carry,
                                                int unsigned period, int unsigned wrap);
    logic [MOD_W-1:0] t;
    t = cur + MOD_W'(TICK_MS) + (carry ? MOD_W'(period - wrap) : MOD_W'(0));
    if (t >= MOD_W'(period)) begin
      t = t - MOD_W'(period);
    end
    if (t >= MOD_W'(period)) begin
      t = t - MOD_W'(period);
    end
    return t;
  endfunction

  function automatic logic [IDX_W-1:0] breathe_idx(logic [BR_W-1:0] m);
    logic [31:0] p;
    p = 32'(m) * 32'(BREATHE_IDX_MUL);
    return p[IDX_SH +: IDX_W];
  endfunction

  function automatic logic [IDX_W-1:0] pulse_idx(logic [PU_W-1:0] m);
    logic [31:0] p;
    p = 32'(m) * 32'(PULSE_IDX_MUL);
    return p[IDX_SH +: IDX_W];
  endfunction

  function automatic mode_t choose_mode(logic flags_valid, logic flags_nonzero,
                                        logic oven_valid, logic [1:0] oven_code);
    mode_t m;
    if (flags_valid && flags_nonzero) begin
      m = MODE_FAULT;
    end else if (!oven_valid) begin
      m = MODE_BREATHE;
    end else if (oven_code == OVEN_RUNNING) begin
      m = MODE_PULSE;
    end else if (oven_code == OVEN_FAULT) begin
      m = MODE_FAULT;
    end else begin
      m = MODE_BREATHE;
    end
    return m;
  endfunction

  function automatic logic [1:0] mode_code(mode_t m);
    logic [1:0] c;
    unique case (m)
      MODE_BOOT:    c = CODE_BOOT;
      MODE_BREATHE: c = CODE_BREATHE;
      MODE_PULSE:   c = CODE_PULSE;
      MODE_FAULT:   c = CODE_FAULT;
      default:      c = CODE_BOOT;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/status_led_animation_controller.sv
// Status LED animator: phase counter, mode selection and colour generation.
// Depends on slac_pkg and status_led_animation_controller_macros.svh.
//
// Usage:
// - Input channel (in_valid/in_ready): one transaction per timer tick or fault
//   event. A tick advances the phase by TICK_MS and yields one colour; a fault
//   event forces fault blink, keeps the phase and yields no transaction.
// - Result channel (out_valid/out_ready): red, green, blue and the mode code
//   that produced them.
// - Output: a tick's colour is registered and valid the cycle after it is accepted.
// - Throughput: one item per cycle while the result channel is not stalled; colour,
//   phase residues and next mode are all computed combinationally between the state and output registers.
// - Phase residues modulo 4000, 1500 and 400 ms run beside the 32-bit phase,
//   so the sine index is a constant reciprocal multiply into a level table.
// - Stall: while a colour waits and out_ready is low, in_ready is low and the
//   colour holds. With out_ready high a new item is taken in the same cycle
//   the waiting colour leaves.
// - Reset: boot flash mode, phase zero, no colour pending.
`default_nettype none
`include "status_led_animation_controller_macros.svh"

module status_led_animation_controller
  import slac_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_kind,
  input  wire logic       in_fault_flags_valid,
  input  wire logic       in_fault_flags_nonzero,
  input  wire logic       in_oven_state_valid,
  input  wire logic [1:0] in_oven_state,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [1:0]      out_mode
);

  mode_t              mode_r, mode_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BR_W-1:0]    br_mod_r, br_mod_nxt;
  logic [PU_W-1:0]    pu_mod_r, pu_mod_nxt;
  logic [BL_W-1:0]    bl_mod_r, bl_mod_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         red_r, red_nxt;
  logic [7:0]         green_r, green_nxt;
  logic [7:0]         blue_r, blue_nxt;
  logic [1:0]         code_r, code_nxt;

  logic               in_fire;
  logic               tick;
  logic               fault_ev;
  logic               carry;
  logic [PHASE_W-1:0] phase_sum;
  logic [BR_W-1:0]    br_step;
  logic [PU_W-1:0]    pu_step;
  logic [BL_W-1:0]    bl_step;
  logic [BL_W-1:0]    boot_half;
  mode_t              want;
  logic [7:0]         red_c, green_c, blue_c;

  assign in_ready = !out_valid_r || out_ready;

  always_comb begin
    in_fire  = in_valid && in_ready;
    tick     = in_fire && (in_kind == KIND_TICK);
    fault_ev = in_fire && (in_kind == KIND_FAULT);

    {carry, phase_sum} = {1'b0, phase_r} + (PHASE_W + 1)'(TICK_MS);
    br_step = BR_W'(mod_step(MOD_W'(br_mod_r), carry, BREATHE_PERIOD, BREATHE_WRAP));
    pu_step = PU_W'(mod_step(MOD_W'(pu_mod_r), carry, PULSE_PERIOD, PULSE_WRAP));
    bl_step = BL_W'(mod_step(MOD_W'(bl_mod_r), carry, BLINK_PERIOD, BLINK_WRAP));

    want = choose_mode(in_fault_flags_valid, in_fault_flags_nonzero,
                       in_oven_state_valid, in_oven_state);

    // phase mod 200, from the mod-400 residue
    boot_half = (bl_step >= BL_W'(BLINK_HALF_MS)) ? bl_step - BL_W'(BLINK_HALF_MS) : bl_step;

    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    unique case (mode_r)
      MODE_BOOT: begin
        if (boot_half < BL_W'(BOOT_STEP_MS) && phase_sum < PHASE_W'(BOOT_WHITE_END_MS)) begin
          red_c   = BOOT_LEVEL;
          green_c = BOOT_LEVEL;
          blue_c  = BOOT_LEVEL;
        end
      end
      MODE_BREATHE: begin
        blue_c = BREATHE_LVL[breathe_idx(br_step)];
      end
      MODE_PULSE: begin
        red_c   = PULSE_RED_LVL[pulse_idx(pu_step)];
        green_c = PULSE_GREEN_LVL[pulse_idx(pu_step)];
      end
      MODE_FAULT: begin
        if (bl_step < BL_W'(BLINK_HALF_MS)) begin
          red_c = BLINK_LEVEL;
        end
      end
      default: begin
        red_c = '0;
      end
    endcase

    mode_nxt   = mode_r;
    phase_nxt  = phase_r;
    br_mod_nxt = br_mod_r;
    pu_mod_nxt = pu_mod_r;
    bl_mod_nxt = bl_mod_r;
    if (fault_ev) begin
      mode_nxt = MODE_FAULT;
    end else if (tick) begin
      phase_nxt  = phase_sum;
      br_mod_nxt = br_step;
      pu_mod_nxt = pu_step;
      bl_mod_nxt = bl_step;
      if ((mode_r == MODE_BOOT && phase_sum >= PHASE_W'(BOOT_END_MS)) ||
          (mode_r != MODE_BOOT && want != mode_r)) begin
        mode_nxt   = want;
        phase_nxt  = '0;
        br_mod_nxt = '0;
        pu_mod_nxt = '0;
        bl_mod_nxt = '0;
      end
    end

    out_valid_nxt = out_valid_r;
    if (tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    red_nxt   = red_r;
    green_nxt = green_r;
    blue_nxt  = blue_r;
    code_nxt  = code_r;
    if (tick) begin
      red_nxt   = red_c;
      green_nxt = green_c;
      blue_nxt  = blue_c;
      code_nxt  = mode_code(mode_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_BOOT;
      phase_r     <= '0;
      br_mod_r    <= '0;
      pu_mod_r    <= '0;
      bl_mod_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      phase_r     <= phase_nxt;
      br_mod_r    <= br_mod_nxt;
      pu_mod_r    <= pu_mod_nxt;
      bl_mod_r    <= bl_mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    code_r  <= code_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_mode  = code_r;

  `SLAC_ASSERT_NEXT(a_fault_event_mode, fault_ev, mode_r == MODE_FAULT, "fault event did not force fault mode")
  `SLAC_ASSERT_NEXT(a_mode_change_clears, tick && mode_r != MODE_BOOT && want != mode_r, phase_r == '0 && bl_mod_r == '0, "mode change did not clear phase")
  `SLAC_ASSERT(a_residue_range, br_mod_r < BR_W'(BREATHE_PERIOD) && pu_mod_r < PU_W'(PULSE_PERIOD) && bl_mod_r < BL_W'(BLINK_PERIOD), "phase residue out of range")
  `SLAC_ASSERT(a_boot_gray, !(out_valid_r && code_r == CODE_BOOT) || (red_r == green_r && green_r == blue_r), "boot colour not gray")
  `SLAC_ASSERT(a_pulse_orange, !(out_valid_r && code_r == CODE_PULSE) || (blue_r == '0 && green_r <= red_r), "pulse colour not orange")

endmodule

`default_nettype wire

>>> verif/status_led_animation_controller_tb.sv
// Self-checking testbench for status_led_animation_controller: boot flash, breathe, pulse
// and fault blink colors are predicted per tick and compared at the result channel.
// Depends on slac_pkg and the RTL of status_led_animation_controller.
`timescale 1ns / 100ps

module status_led_animation_controller_tb
  import slac_pkg::*;
();

  localparam logic [1:0] OVEN_IDLE  = 2'd0;
  localparam logic [1:0] OVEN_SPARE = 2'd3;

  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 600;

  // 65536 * sin(k * pi / 64), k = 0..32
  localparam int unsigned QUARTER_SINE [0:32] = '{
    0, 3216, 6424, 9616, 12785, 15924, 19024, 22078,
    25079, 28020, 30893, 33692, 36410, 39040, 41576, 44011,
    46341, 48559, 50660, 52639, 54491, 56212, 57798, 59244,
    60547, 61705, 62714, 63572, 64277, 64827, 65220, 65457,
    65536
  };

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] mode;
  } led_colour_t;

  class led_colour_scoreboard;
    logic [1:0]  anim_mode;
    logic [31:0] phase_acc;
    led_colour_t awaited[$];
    int unsigned errors;

    function new();
      anim_mode = CODE_BOOT;
      phase_acc = '0;
      errors    = 0;
    endfunction

    static function logic [1:0] pick_mode(logic fv, logic fn, logic ov, logic [1:0] os);
      if (fv && fn) return CODE_FAULT;
      if (!ov) return CODE_BREATHE;
      if (os == OVEN_RUNNING) return CODE_PULSE;
      if (os == OVEN_FAULT) return CODE_FAULT;
      return CODE_BREATHE;
    endfunction

    function logic [7:0] sine_level(logic [31:0] phase, int unsigned period,
                                    int unsigned peak);
      int unsigned m;
      int unsigned idx;
      int unsigned mag;
      int unsigned biased;
      m      = phase % period;
      idx    = (m * 128) / period;
      mag    = ((idx >> 5) & 1) != 0 ? QUARTER_SINE[32 - (idx & 31)] : QUARTER_SINE[idx & 31];
      biased = ((idx >> 5) & 2) != 0 ? 65536 - mag : 65536 + mag;
      return 8'((peak * biased) >> 17);
    endfunction

    function void note_input(logic kind, logic fv, logic fn, logic ov, logic [1:0] os);
      led_colour_t c;
      logic [1:0]  want;
      if (kind == KIND_FAULT) begin
        anim_mode = CODE_FAULT;
        return;
      end
      phase_acc = phase_acc + 32'(TICK_MS);
      c = '0;
      c.mode = anim_mode;
      case (anim_mode)
        CODE_BOOT: begin
          if (((phase_acc / 100) % 2) == 0 && phase_acc < 400) begin
            c.red   = 8'd20;
            c.green = 8'd20;
            c.blue  = 8'd20;
          end
          if (phase_acc >= 800) begin
            anim_mode = pick_mode(fv, fn, ov, os);
            phase_acc = '0;
          end
        end
        CODE_BREATHE: c.blue = sine_level(phase_acc, 4000, 30);
        CODE_PULSE: begin
          c.red   = sine_level(phase_acc, 1500, 60);
          c.green = c.red / 3;
        end
        default: if (((phase_acc / 200) % 2) == 0) c.red = 8'd80;
      endcase
      if (c.mode != CODE_BOOT) begin
        want = pick_mode(fv, fn, ov, os);
        if (want != c.mode) begin
          anim_mode = want;
          phase_acc = '0;
        end
      end
      awaited.push_back(c);
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 10) $display("%s", msg);
    endfunction

    function void check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [1:0] mode);
      led_colour_t want;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected color r=%0d g=%0d b=%0d mode=%0d", r, g, b, mode));
        return;
      end
      want = awaited.pop_front();
      if (want.red !== r || want.green !== g || want.blue !== b || want.mode !== mode)
        report($sformatf("color exp r=%0d g=%0d b=%0d mode=%0d got r=%0d g=%0d b=%0d mode=%0d",
                         want.red, want.green, want.blue, want.mode, r, g, b, mode));
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_kind = 1'b0;
  logic       in_fault_flags_valid = 1'b0;
  logic       in_fault_flags_nonzero = 1'b0;
  logic       in_oven_state_valid = 1'b0;
  logic [1:0] in_oven_state = 2'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [1:0] out_mode;

  led_colour_scoreboard sb = new();
  bit          idle_en = 1'b1;
  int unsigned items_offered = 0;

  status_led_animation_controller u_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_kind                (in_kind),
    .in_fault_flags_valid   (in_fault_flags_valid),
    .in_fault_flags_nonzero (in_fault_flags_nonzero),
    .in_oven_state_valid    (in_oven_state_valid),
    .in_oven_state          (in_oven_state),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_red                (out_red),
    .out_green              (out_green),
    .out_blue               (out_blue),
    .out_mode               (out_mode)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_event(logic kind, logic fv, logic fn, logic ov, logic [1:0] os);
    int unsigned gap;
    in_valid               <= 1'b1;
    in_kind                <= kind;
    in_fault_flags_valid   <= fv;
    in_fault_flags_nonzero <= fn;
    in_oven_state_valid    <= ov;
    in_oven_state          <= os;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(kind, fv, fn, ov, os);
    items_offered++;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic noise_burst();
    int unsigned n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      offer_event($urandom_range(0, 3) == 0 ? KIND_FAULT : KIND_TICK, 1'($urandom),
                  1'($urandom), 1'($urandom), 2'($urandom));
    end
  endtask

  // ticks whose inputs all select the same mode, with random content and occasional fault events
  task automatic steady_run(logic [1:0] target);
    int unsigned len;
    logic        fv;
    logic        fn;
    logic        ov;
    logic [1:0]  os;
    len = $urandom_range(0, 9) < 7 ? $urandom_range(1, 30) : $urandom_range(60, 130);
    repeat (len) begin
      do begin
        fv = 1'($urandom);
        fn = 1'($urandom);
        ov = 1'($urandom);
        os = 2'($urandom);
      end while (led_colour_scoreboard::pick_mode(fv, fn, ov, os) != target);
      if ($urandom_range(0, 99) < 3)
        offer_event(KIND_FAULT, 1'($urandom), 1'($urandom), 1'($urandom), 2'($urandom));
      offer_event(KIND_TICK, fv, fn, ov, os);
    end
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned colours_seen;
    bit          hold_done;
    stall_left   = 0;
    hold_left    = 0;
    colours_seen = 0;
    hold_done    = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_red, out_green, out_blue, out_mode);
        colours_seen++;
      end
      if (!hold_done && colours_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready  <= 1'b1;
        stall_left = gap_len();
      end
    end
  end

  initial begin
    int unsigned sel;
    bit          paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // boot flash with varied inputs, then a fault event before boot ends
    for (int i = 0; i < 12; i++) begin
      offer_event(KIND_TICK, 1'(i), 1'(i >> 1), 1'(i >> 2), 2'(i));
    end
    offer_event(KIND_FAULT, 1'b0, 1'b0, 1'b0, OVEN_IDLE);
    offer_event(KIND_TICK, 1'b1, 1'b1, 1'b0, OVEN_IDLE);
    offer_event(KIND_TICK, 1'b0, 1'b1, 1'b1, OVEN_FAULT);
    offer_event(KIND_TICK, 1'b0, 1'b0, 1'b1, OVEN_RUNNING);
    offer_event(KIND_TICK, 1'b1, 1'b0, 1'b1, OVEN_RUNNING);
    offer_event(KIND_TICK, 1'b0, 1'b0, 1'b1, OVEN_IDLE);
    offer_event(KIND_TICK, 1'b0, 1'b0, 1'b1, OVEN_SPARE);
    offer_event(KIND_TICK, 1'b0, 1'b0, 1'b0, OVEN_RUNNING);
    offer_event(KIND_TICK, 1'b0, 1'b1, 1'b1, OVEN_RUNNING);
    offer_event(KIND_FAULT, 1'b1, 1'b1, 1'b1, OVEN_SPARE);
    offer_event(KIND_TICK, 1'b0, 1'b1, 1'b1, OVEN_RUNNING);
    offer_event(KIND_TICK, 1'b1, 1'b0, 1'b1, OVEN_FAULT);
    offer_event(KIND_FAULT, 1'b0, 1'b0, 1'b1, OVEN_FAULT);
    offer_event(KIND_TICK, 1'b1, 1'b1, 1'b1, OVEN_FAULT);
    pause_until_drained();

    items_offered = 0;
    while (items_offered < RANDOM_ITEMS) begin
      idle_en = $urandom_range(0, 3) != 0;
      if (!paused && items_offered >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        pause_until_drained();
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) noise_burst();
      else if (sel < 45) steady_run(CODE_BREATHE);
      else if (sel < 75) steady_run(CODE_PULSE);
      else steady_run(CODE_FAULT);
    end

    pause_until_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> status_led_animation_controller.f
+incdir+hdl
hdl/slac_pkg.sv
hdl/status_led_animation_controller.sv
verif/status_led_animation_controller_tb.sv
